[hdl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the frame checker rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/frc_pkg.sv]
// ----------------------------------------------------------------------------
// frc_pkg
// types and codes for the received frame checker
// ----------------------------------------------------------------------------
`default_nettype none

package frc_pkg;

  localparam int BYTE_W     = 8;
  localparam int STATUS_W   = 3;
  localparam int CFG_INDEX_W = 8;

  localparam logic [CFG_INDEX_W-1:0] REG_EXPECTED_ID = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAX_LENGTH  = 8'd1;

  localparam logic [BYTE_W-1:0] EXPECTED_ID_RESET = 8'd0;
  localparam logic [BYTE_W-1:0] MAX_LENGTH_RESET  = 8'd255;

  typedef enum logic [1:0] {
    PH_ID   = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2,
    PH_SUM  = 2'd3
  } phase_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ID_OK    = 3'd0,
    ST_LEN_OK   = 3'd1,
    ST_PAYLOAD  = 3'd2,
    ST_FRAME_OK = 3'd3,
    ST_ID_BAD   = 3'd4,
    ST_TOO_LONG = 3'd5,
    ST_SUM_BAD  = 3'd6
  } status_t;

  typedef struct packed {
    logic [BYTE_W-1:0] expected_id;
    logic [BYTE_W-1:0] max_length;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic [BYTE_W-1:0] data_byte;
    logic [BYTE_W-1:0] payload_index;
    logic              frame_end;
  } result_t;

endpackage

`default_nettype wire

[hdl/frc_byte_if.sv]
// ----------------------------------------------------------------------------
// frc_byte_if
// received byte channel
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_byte_if;
  logic                         valid;
  logic                         ready;
  logic [frc_pkg::BYTE_W-1:0]   rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

[hdl/frc_result_if.sv]
// ----------------------------------------------------------------------------
// frc_result_if
// per-byte result channel
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_result_if;
  logic                         valid;
  logic                         ready;
  logic [frc_pkg::STATUS_W-1:0] status;
  logic [frc_pkg::BYTE_W-1:0]   data_byte;
  logic [frc_pkg::BYTE_W-1:0]   payload_index;
  logic                         frame_end;

  modport source (output valid, output status, output data_byte, output payload_index,
                  output frame_end, input ready);
  modport sink   (input valid, input status, input data_byte, input payload_index,
                  input frame_end, output ready);
endinterface

`default_nettype wire

[hdl/frc_cfg_if.sv]
// ----------------------------------------------------------------------------
// frc_cfg_if
// register write channel
// ----------------------------------------------------------------------------
`default_nettype none

interface frc_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [frc_pkg::CFG_INDEX_W-1:0] index;
  logic [frc_pkg::BYTE_W-1:0]      data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/frc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// frc_cfg_regs
// expected id and maximum length registers
// ----------------------------------------------------------------------------
`default_nettype none

module frc_cfg_regs (
  input  wire logic   clk,
  input  wire logic   rst,
  frc_cfg_if.sink     cfg,
  output frc_pkg::cfg_t regs
);

  logic cfg_xfer;

  assign cfg.ready = 1'b1;
  assign cfg_xfer  = cfg.valid & cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.expected_id <= frc_pkg::EXPECTED_ID_RESET;
      regs.max_length  <= frc_pkg::MAX_LENGTH_RESET;
    end else if (cfg_xfer) begin
      case (cfg.index)
        frc_pkg::REG_EXPECTED_ID: regs.expected_id <= cfg.data;
        frc_pkg::REG_MAX_LENGTH:  regs.max_length  <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

[hdl/frc_frame_fsm.sv]
// ----------------------------------------------------------------------------
// frc_frame_fsm
// frame phase tracking, payload count, running sum and per-byte result
// ----------------------------------------------------------------------------
`default_nettype none

module frc_frame_fsm (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       take,
  input  wire logic [frc_pkg::BYTE_W-1:0] rx_byte,
  input  wire frc_pkg::cfg_t              regs,
  output frc_pkg::result_t                result
);

  frc_pkg::phase_t             phase, phase_next;
  logic [frc_pkg::BYTE_W-1:0]  frame_length, frame_length_next;
  logic [frc_pkg::BYTE_W-1:0]  payload_count, payload_count_next;
  logic [frc_pkg::BYTE_W-1:0]  running_sum, running_sum_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= frc_pkg::PH_ID;
      frame_length  <= '0;
      payload_count <= '0;
      running_sum   <= '0;
    end else if (take) begin
      phase         <= phase_next;
      frame_length  <= frame_length_next;
      payload_count <= payload_count_next;
      running_sum   <= running_sum_next;
    end
  end

  always_comb begin
    phase_next           = phase;
    frame_length_next    = frame_length;
    payload_count_next   = payload_count;
    running_sum_next     = running_sum;
    result.status        = frc_pkg::ST_ID_OK;
    result.data_byte     = rx_byte;
    result.payload_index = '0;
    result.frame_end     = 1'b0;
    case (phase)
      frc_pkg::PH_ID: begin
        if (rx_byte == regs.expected_id) begin
          result.status      = frc_pkg::ST_ID_OK;
          running_sum_next   = '0;
          payload_count_next = '0;
          phase_next         = frc_pkg::PH_LEN;
        end else begin
          result.status    = frc_pkg::ST_ID_BAD;
          result.frame_end = 1'b1;
          phase_next       = frc_pkg::PH_ID;
        end
      end
      frc_pkg::PH_LEN: begin
        if (rx_byte <= regs.max_length) begin
          result.status      = frc_pkg::ST_LEN_OK;
          frame_length_next  = rx_byte;
          payload_count_next = '0;
          running_sum_next   = '0;
          phase_next         = (rx_byte == '0) ? frc_pkg::PH_SUM : frc_pkg::PH_DATA;
        end else begin
          result.status    = frc_pkg::ST_TOO_LONG;
          result.frame_end = 1'b1;
          phase_next       = frc_pkg::PH_ID;
        end
      end
      frc_pkg::PH_DATA: begin
        result.status        = frc_pkg::ST_PAYLOAD;
        result.payload_index = payload_count;
        running_sum_next     = running_sum + rx_byte;
        payload_count_next   = payload_count + 8'd1;
        if (payload_count_next == frame_length) begin
          phase_next = frc_pkg::PH_SUM;
        end
      end
      frc_pkg::PH_SUM: begin
        result.status    = (rx_byte == running_sum) ? frc_pkg::ST_FRAME_OK
                                                    : frc_pkg::ST_SUM_BAD;
        result.frame_end = 1'b1;
        phase_next       = frc_pkg::PH_ID;
      end
      default: begin
        phase_next = frc_pkg::PH_ID;
      end
    endcase
  end

endmodule

`default_nettype wire

[hdl/frc_out_reg.sv]
// ----------------------------------------------------------------------------
// frc_out_reg
// result register, refilled in the cycle it is emptied
// ----------------------------------------------------------------------------
`default_nettype none

module frc_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             load,
  input  wire frc_pkg::result_t d,
  output logic                  can_load,
  frc_result_if.source          res
);

  logic             out_valid;
  frc_pkg::result_t out_data;

  assign can_load = ~out_valid | res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_load) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      out_data <= d;
    end
  end

  assign res.valid         = out_valid;
  assign res.status        = out_data.status;
  assign res.data_byte     = out_data.data_byte;
  assign res.payload_index = out_data.payload_index;
  assign res.frame_end     = out_data.frame_end;

endmodule

`default_nettype wire

[hdl/frame_rx_checker_top.sv]
// ----------------------------------------------------------------------------
// frame_rx_checker_top
// checks id, length, payload and sum of frames in a received byte stream
// ----------------------------------------------------------------------------
// One byte is taken per cycle unless stalled, and every byte gives one
// result, in the cycle after its transfer, from a single result register.
// A new byte is taken whenever that register is empty or is being read in
// the same cycle, so a stalled sink holds the input back after one byte.
// Register writes take effect on the next byte and are accepted at any time.
`default_nettype none

`include "assert_macros.svh"

module frame_rx_checker_top (
  input  wire logic     clk,
  input  wire logic     rst,
  frc_byte_if.sink      rx,
  frc_result_if.source  res,
  frc_cfg_if.sink       cfg
);

  frc_pkg::cfg_t    regs;
  frc_pkg::result_t result;
  logic             can_load;
  logic             take;

  assign rx.ready = can_load;
  assign take     = rx.valid & can_load;

  frc_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .regs (regs)
  );

  frc_frame_fsm u_frame_fsm (
    .clk     (clk),
    .rst     (rst),
    .take    (take),
    .rx_byte (rx.rx_byte),
    .regs    (regs),
    .result  (result)
  );

  frc_out_reg u_out_reg (
    .clk      (clk),
    .rst      (rst),
    .load     (take),
    .d        (result),
    .can_load (can_load),
    .res      (res)
  );

  `ASSERT_NEXT(a_byte_gives_result, clk, rst, rx.valid && rx.ready, res.valid)
  `ASSERT_IMPL(a_end_matches_status, clk, rst, res.valid,
    res.frame_end == (res.status == frc_pkg::ST_FRAME_OK || res.status == frc_pkg::ST_ID_BAD ||
                      res.status == frc_pkg::ST_TOO_LONG || res.status == frc_pkg::ST_SUM_BAD))
  `ASSERT_IMPL(a_index_only_payload, clk, rst,
    res.valid && (res.status != frc_pkg::ST_PAYLOAD), res.payload_index == '0)

endmodule

`default_nettype wire

[tb/sv/frame_rx_checker_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_rx_checker_top_tb
// self-checking bench for the received frame checker
// ----------------------------------------------------------------------------
// A short table of directed bytes and register writes covers the header and
// sum errors, zero length, extreme ids and lengths, ignored register indexes
// and a length limit changed in the middle of a frame. Random phases follow,
// each with its own id and length limit, sending mostly well formed frames
// with some noise, over-long headers, bad sums and frames split across a
// register write. Each result is checked against its pinned value or a
// predictor kept in step with each accepted byte; both ends stall at random.
// ----------------------------------------------------------------------------
module frame_rx_checker_top_tb;
  import frc_pkg::*;

  localparam int RAND_ITEMS    = 1950;
  localparam int STALL_LIMIT   = 2000;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LOW = REG_MAX_LENGTH + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_TOP = '1;

  typedef logic [BYTE_W-1:0] octet_t;

  typedef enum logic {
    ROW_BYTE,
    ROW_REG
  } row_kind_t;

  typedef struct {
    row_kind_t               kind;
    logic [CFG_INDEX_W-1:0]  index;
    octet_t                  value;
    bit                      pinned;
    result_t                 res;
  } plan_row_t;

  typedef struct {
    bit      pinned;
    result_t res;
  } pin_t;

  localparam result_t NO_PIN = '0;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  frc_byte_if   rx_if ();
  frc_result_if res_if ();
  frc_cfg_if    cfg_if ();

  frame_rx_checker_top dut (
    .clk (clk),
    .rst (rst),
    .rx  (rx_if),
    .res (res_if),
    .cfg (cfg_if)
  );

  // predictor copy of registers and frame state
  octet_t  id_reg;
  octet_t  max_reg;
  phase_t  rx_phase;
  octet_t  hdr_len;
  octet_t  pay_cnt;
  octet_t  pay_sum;

  result_t     expected_results[$];
  pin_t        pinned_q[$];
  int unsigned error_count  = 0;
  int unsigned quiet_cycles = 0;
  bit          tx_calm      = 1'b0;
  bit          sink_calm    = 1'b0;

  function automatic result_t frame_predict(octet_t b);
    result_t r;
    r.status        = ST_ID_OK;
    r.data_byte     = b;
    r.payload_index = '0;
    r.frame_end     = 1'b0;
    case (rx_phase)
      PH_ID: begin
        if (b == id_reg) begin
          pay_sum  = '0;
          pay_cnt  = '0;
          rx_phase = PH_LEN;
        end else begin
          r.status    = ST_ID_BAD;
          r.frame_end = 1'b1;
        end
      end
      PH_LEN: begin
        if (b <= max_reg) begin
          r.status = ST_LEN_OK;
          hdr_len  = b;
          pay_cnt  = '0;
          pay_sum  = '0;
          rx_phase = (b == '0) ? PH_SUM : PH_DATA;
        end else begin
          r.status    = ST_TOO_LONG;
          r.frame_end = 1'b1;
          rx_phase    = PH_ID;
        end
      end
      PH_DATA: begin
        r.status        = ST_PAYLOAD;
        r.payload_index = pay_cnt;
        pay_sum         = pay_sum + b;
        pay_cnt         = pay_cnt + 1'b1;
        if (pay_cnt == hdr_len) rx_phase = PH_SUM;
      end
      default: begin
        r.status    = (b == pay_sum) ? ST_FRAME_OK : ST_SUM_BAD;
        r.frame_end = 1'b1;
        rx_phase    = PH_ID;
      end
    endcase
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      error_count++;
    end
  endfunction

  function automatic int unsigned pause_len(bit calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic octet_t pick_len(octet_t limit);
    if ($urandom_range(0, 19) == 0) return octet_t'($urandom_range(0, limit));
    return octet_t'($urandom_range(0, (limit < 8) ? limit : 8));
  endfunction

  function automatic plan_row_t row_byte(octet_t b);
    plan_row_t r;
    r.kind   = ROW_BYTE;
    r.index  = '0;
    r.value  = b;
    r.pinned = 1'b0;
    r.res    = NO_PIN;
    return r;
  endfunction

  function automatic plan_row_t row_pin(octet_t b, status_t st, octet_t idx, logic fe);
    plan_row_t r;
    r                   = row_byte(b);
    r.pinned            = 1'b1;
    r.res.status        = st;
    r.res.data_byte     = b;
    r.res.payload_index = idx;
    r.res.frame_end     = fe;
    return r;
  endfunction

  function automatic plan_row_t row_reg(logic [CFG_INDEX_W-1:0] index, octet_t value);
    plan_row_t r;
    r       = row_byte(value);
    r.kind  = ROW_REG;
    r.index = index;
    return r;
  endfunction

  task automatic send_byte(octet_t b, bit pinned, result_t res);
    pin_t        p;
    int unsigned gap;
    gap = pause_len(tx_calm);
    repeat (gap) begin
      @(negedge clk);
      rx_if.valid <= 1'b0;
    end
    @(negedge clk);
    p.pinned = pinned;
    p.res    = res;
    pinned_q.push_back(p);
    rx_if.valid   <= 1'b1;
    rx_if.rx_byte <= b;
    @(posedge clk);
    while (!rx_if.ready) @(posedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    rx_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic reg_write(logic [CFG_INDEX_W-1:0] index, octet_t value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= index;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic build_frame(ref octet_t q[$], input octet_t id, input octet_t len,
                             input bit good_sum);
    octet_t sum;
    octet_t b;
    sum = '0;
    q.push_back(id);
    q.push_back(len);
    for (int i = 0; i < len; i++) begin
      b   = octet_t'($urandom);
      sum = sum + b;
      q.push_back(b);
    end
    if (!good_sum) sum = sum ^ octet_t'($urandom_range(1, 255));
    q.push_back(sum);
  endtask

  always @(posedge clk) begin : monitor
    result_t want;
    pin_t    pin;
    if (rst) begin
      id_reg   = EXPECTED_ID_RESET;
      max_reg  = MAX_LENGTH_RESET;
      rx_phase = PH_ID;
      hdr_len  = '0;
      pay_cnt  = '0;
      pay_sum  = '0;
    end else begin
      if ((cfg_if.valid && cfg_if.ready) || (rx_if.valid && rx_if.ready)
          || (res_if.valid && res_if.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (cfg_if.valid && cfg_if.ready) begin
        if (cfg_if.index == REG_EXPECTED_ID) id_reg = cfg_if.data;
        else if (cfg_if.index == REG_MAX_LENGTH) max_reg = cfg_if.data;
      end
      if (rx_if.valid && rx_if.ready) begin
        want = frame_predict(rx_if.rx_byte);
        pin  = pinned_q.pop_front();
        expected_results.push_back(pin.pinned ? pin.res : want);
      end
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected, actual status %0d data %0h",
                   $time, res_if.status, res_if.data_byte);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", want.status, res_if.status);
          check_field("data_byte", want.data_byte, res_if.data_byte);
          check_field("payload_index", want.payload_index, res_if.payload_index);
          check_field("frame_end", want.frame_end, res_if.frame_end);
        end
      end
    end
  end

  initial begin : sink
    int unsigned gap;
    res_if.ready = 1'b0;
    forever begin
      gap = pause_len(sink_calm);
      repeat (gap) begin
        @(negedge clk);
        res_if.ready <= 1'b0;
      end
      @(negedge clk);
      res_if.ready <= 1'b1;
      @(posedge clk);
      while (!res_if.valid) @(posedge clk);
    end
  end

  initial begin : watchdog
    while (quiet_cycles < STALL_LIMIT) @(posedge clk);
    $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin : stimulus
    plan_row_t   plan[$];
    octet_t      burst[$];
    octet_t      carry[$];
    octet_t      partial[$];
    octet_t      cur_id;
    octet_t      cur_max;
    octet_t      b;
    int unsigned sent;
    int unsigned cut;
    int unsigned kind;
    bit          first;

    rx_if.valid   = 1'b0;
    rx_if.rx_byte = '0;
    cfg_if.valid  = 1'b0;
    cfg_if.index  = '0;
    cfg_if.data   = '0;

    // reset values: id 0, limit 255; zero length frame, then an id mismatch
    plan.push_back(row_pin(8'h00, ST_ID_OK, 8'h00, 1'b0));
    plan.push_back(row_pin(8'h00, ST_LEN_OK, 8'h00, 1'b0));
    plan.push_back(row_pin(8'h00, ST_FRAME_OK, 8'h00, 1'b1));
    plan.push_back(row_pin(8'hFF, ST_ID_BAD, 8'h00, 1'b1));
    // good frame with full-scale payload, then a bad sum
    plan.push_back(row_byte(8'h00));
    plan.push_back(row_byte(8'h02));
    plan.push_back(row_byte(8'hFF));
    plan.push_back(row_byte(8'hFF));
    plan.push_back(row_byte(8'hFE));
    plan.push_back(row_byte(8'h00));
    plan.push_back(row_byte(8'h01));
    plan.push_back(row_byte(8'h05));
    plan.push_back(row_pin(8'h07, ST_SUM_BAD, 8'h00, 1'b1));
    // id 255, limit 0
    plan.push_back(row_reg(REG_EXPECTED_ID, 8'hFF));
    plan.push_back(row_reg(REG_MAX_LENGTH, 8'h00));
    plan.push_back(row_pin(8'h00, ST_ID_BAD, 8'h00, 1'b1));
    plan.push_back(row_byte(8'hFF));
    plan.push_back(row_pin(8'h01, ST_TOO_LONG, 8'h00, 1'b1));
    plan.push_back(row_byte(8'hFF));
    plan.push_back(row_byte(8'h00));
    plan.push_back(row_pin(8'h00, ST_FRAME_OK, 8'h00, 1'b1));
    // limit lowered in mid frame, frame keeps its stored length
    plan.push_back(row_reg(REG_MAX_LENGTH, 8'h03));
    plan.push_back(row_byte(8'hFF));
    plan.push_back(row_byte(8'h03));
    plan.push_back(row_byte(8'h80));
    plan.push_back(row_reg(REG_MAX_LENGTH, 8'h00));
    plan.push_back(row_byte(8'h80));
    plan.push_back(row_byte(8'h01));
    plan.push_back(row_byte(8'h01));
    plan.push_back(row_byte(8'hFF));
    plan.push_back(row_pin(8'h04, ST_TOO_LONG, 8'h00, 1'b1));
    // writes to unused indexes leave the registers alone
    plan.push_back(row_reg(REG_SPARE_LOW, 8'h00));
    plan.push_back(row_reg(REG_SPARE_TOP, 8'h00));
    plan.push_back(row_reg(REG_MAX_LENGTH, 8'hFF));
    plan.push_back(row_byte(8'hFF));
    plan.push_back(row_byte(8'h00));
    plan.push_back(row_pin(8'h01, ST_SUM_BAD, 8'h00, 1'b1));

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_REG) begin
        drain();
        reg_write(plan[i].index, plan[i].value);
      end else begin
        send_byte(plan[i].value, plan[i].pinned, plan[i].res);
      end
    end

    cur_id  = 8'hFF;
    cur_max = 8'hFF;
    sent    = 0;
    first   = 1'b1;
    while (sent < RAND_ITEMS) begin
      drain();
      case ($urandom_range(0, 3))
        0:       cur_id = '0;
        1:       cur_id = '1;
        default: cur_id = octet_t'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0:       cur_max = '0;
        1:       cur_max = '1;
        2:       cur_max = octet_t'($urandom);
        default: cur_max = octet_t'($urandom_range(1, 12));
      endcase
      if (first) cur_max = '1;
      if ($urandom_range(0, 1)) begin
        reg_write(REG_EXPECTED_ID, cur_id);
        reg_write(REG_MAX_LENGTH, cur_max);
      end else begin
        reg_write(REG_MAX_LENGTH, cur_max);
        reg_write(REG_EXPECTED_ID, cur_id);
      end
      if ($urandom_range(0, 3) == 0)
        reg_write(CFG_INDEX_W'($urandom_range(REG_SPARE_LOW, REG_SPARE_TOP)),
                  octet_t'($urandom));
      tx_calm   = ($urandom_range(0, 3) == 0);
      sink_calm = ($urandom_range(0, 3) == 0);

      // tail of a frame left open across the register writes
      burst = carry;
      carry.delete();
      repeat ($urandom_range(3, 10)) begin
        kind = first ? 2 : $urandom_range(0, 9);
        case (kind)
          0: begin
            repeat ($urandom_range(1, 3)) begin
              b = octet_t'($urandom);
              if (b == cur_id) b = ~b;
              burst.push_back(b);
            end
          end
          1: begin
            if (cur_max != '1) begin
              burst.push_back(cur_id);
              burst.push_back(octet_t'($urandom_range(cur_max + 1, 255)));
            end else begin
              burst.push_back(~cur_id);
            end
          end
          default: build_frame(burst, cur_id, first ? 8'hFF : pick_len(cur_max),
                               $urandom_range(0, 9) != 0);
        endcase
        first = 1'b0;
      end
      if ($urandom_range(0, 2) == 0) begin
        build_frame(partial, cur_id, pick_len(cur_max), 1'b1);
        cut = $urandom_range(1, partial.size() - 1);
        foreach (partial[i]) begin
          if (i < cut) burst.push_back(partial[i]);
          else carry.push_back(partial[i]);
        end
        partial.delete();
      end
      foreach (burst[i]) send_byte(burst[i], 1'b0, NO_PIN);
      sent += burst.size();
    end
    foreach (carry[i]) send_byte(carry[i], 1'b0, NO_PIN);
    drain();

    if (error_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
